// ===== hdl/sih_pkg.sv =====
// Package for the shared interrupt handler table.
// Holds the command codes, the request and response transfer types and the
// control and status bundles between the controller and the datapath.
package sih_pkg;

    localparam int TAG_W      = 32;
    localparam int LINE_W     = 8;
    localparam int SLOT_IDX_W = 2;
    localparam int COUNT_W    = 3;

    // Slots on each line; the slot index and count fields are sized for it.
    localparam int SLOTS_PER_LINE = 4;

    typedef enum logic [1:0] {
        CMD_REGISTER   = 2'd0,
        CMD_UNREGISTER = 2'd1,
        CMD_DISPATCH   = 2'd2,
        CMD_COUNT      = 2'd3
    } command_t;

    typedef struct packed {
        command_t           command;
        logic [LINE_W-1:0]  line;
        logic [TAG_W-1:0]   handler_tag;
        logic [TAG_W-1:0]   context_tag;
    } request_t;

    typedef struct packed {
        logic                  ok;
        logic                  entry_present;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [TAG_W-1:0]      found_handler;
        logic [TAG_W-1:0]      found_context;
        logic [COUNT_W-1:0]    handler_count;
        logic                  last;
    } response_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic scan_step;
        logic finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic skip_scan;
        logic scan_end;
        logic stall;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/sih_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the handler and context tag store.
module sih_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hdl/sih_ctrl.sv =====
// Controller state machine of the shared interrupt handler table.
// Depends on sih_pkg for the command and status bundles.
module sih_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_ready,
    input  sih_pkg::dp_status_t status,
    output sih_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        request_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                request_ready = 1'b1;
                if (request_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = status.skip_scan ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.stall)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_end)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sih_datapath.sv =====
// Datapath of the shared interrupt handler table: tag store, slot scan,
// pending dispatch entry and the response output register.
// Depends on sih_pkg and sih_ram.
module sih_datapath #(
    parameter int LINE_COUNT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sih_pkg::request_t   request,
    output sih_pkg::response_t  response,
    output logic                response_valid,
    input  logic                response_ready,
    input  sih_pkg::ctrl_cmd_t  cmd,
    output sih_pkg::dp_status_t status
);

    localparam int SLOTS_PER_LINE = sih_pkg::SLOTS_PER_LINE;
    localparam int DEPTH = LINE_COUNT * SLOTS_PER_LINE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
    localparam int TW    = sih_pkg::TAG_W;

    // Item registers.
    sih_pkg::command_t        cmd_reg;
    logic [TW-1:0]            hnd_reg;
    logic [TW-1:0]            ctx_reg;
    logic                     line_ok_reg;
    logic [AW-1:0]            base_reg;
    logic [SW-1:0]            slot_reg;

    // Scan results.
    logic                     hit_found_reg;
    logic                     free_found_reg;
    logic [SW-1:0]            vacant_slot_reg;
    logic [sih_pkg::COUNT_W-1:0] count_reg;

    // Dispatch entry held back until it is known whether another follows.
    logic                     pend_valid_reg;
    logic [SW-1:0]            pend_slot_reg;
    logic [TW-1:0]            pend_hnd_reg;
    logic [TW-1:0]            pend_ctx_reg;

    // Clearing pass and output register.
    logic [AW-1:0]            clear_addr_reg;
    sih_pkg::response_t       rsp_reg;
    sih_pkg::response_t       rsp_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;

    // Request decode.
    logic                     line_ok_req;
    logic                     is_regunreg_req;
    logic [AW-1:0]            base_req;

    // Store access.
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [2*TW-1:0]          wr_data;
    logic [AW-1:0]            rd_addr;
    logic [2*TW-1:0]          rd_data;
    logic [TW-1:0]            entry_hnd;
    logic [TW-1:0]            entry_ctx;
    logic [AW-1:0]            slot_addr;

    logic                     is_register;
    logic                     is_unregister;
    logic                     is_dispatch;
    logic                     is_count;
    logic                     occupied;
    logic                     hit;
    logic                     last_slot;
    logic                     out_free;
    logic                     emit_step;

    // Decode of the incoming request.
    assign line_ok_req     = 32'(request.line) < 32'(LINE_COUNT);
    assign is_regunreg_req = (request.command == sih_pkg::CMD_REGISTER) ||
                             (request.command == sih_pkg::CMD_UNREGISTER);
    assign base_req        = line_ok_req ?
                             AW'(32'(request.line) * 32'(SLOTS_PER_LINE)) : '0;

    // Decode of the item in progress and of the slot just read.
    assign is_register   = cmd_reg == sih_pkg::CMD_REGISTER;
    assign is_unregister = cmd_reg == sih_pkg::CMD_UNREGISTER;
    assign is_dispatch   = cmd_reg == sih_pkg::CMD_DISPATCH;
    assign is_count      = cmd_reg == sih_pkg::CMD_COUNT;
    assign entry_hnd     = rd_data[2*TW-1:TW];
    assign entry_ctx     = rd_data[TW-1:0];
    assign occupied      = entry_hnd != '0;
    assign hit           = (entry_hnd == hnd_reg) && (entry_ctx == ctx_reg);
    assign last_slot     = slot_reg == SW'(SLOTS_PER_LINE - 1);
    assign slot_addr     = AW'(base_reg + AW'(slot_reg));
    assign out_free      = !rsp_valid_reg || response_ready;
    assign emit_step     = cmd.scan_step && is_dispatch && occupied && pend_valid_reg;

    // Status towards the controller.
    always_comb
    begin
        status.clear_last = clear_addr_reg == AW'(DEPTH - 1);
        status.skip_scan  = !line_ok_req ||
                            (is_regunreg_req && (request.handler_tag == '0));
        status.scan_end   = last_slot || (hit && (is_register || is_unregister));
        status.stall      = is_dispatch && occupied && pend_valid_reg && !out_free;
        status.out_free   = out_free;
    end

    // Read address: the first slot of the line on load, otherwise the next
    // slot when the scan moves on and the same slot again when it waits.
    always_comb
    begin
        if (cmd.load_item)
        begin
            rd_addr = base_req;
        end
        else if (cmd.scan_step && !last_slot)
        begin
            rd_addr = AW'(slot_addr + AW'(1));
        end
        else
        begin
            rd_addr = slot_addr;
        end
    end

    // Write port: clearing pass, removal of a matching slot, or filling the
    // first free slot once the whole line has been scanned.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clear_addr_reg;
        wr_data = '0;
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.scan_step && is_unregister && hit)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_addr;
        end
        else if (cmd.finish && is_register && !hit_found_reg && free_found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(base_reg + AW'(vacant_slot_reg));
            wr_data = {hnd_reg, ctx_reg};
        end
    end

    sih_ram #(
        .WIDTH (2 * TW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Response composition: an intermediate dispatch entry or the final response of a command.
    always_comb
    begin
        rsp_next = '0;
        if (cmd.finish)
        begin
            rsp_next.last = 1'b1;
            case (cmd_reg)
                sih_pkg::CMD_REGISTER:
                begin
                    rsp_next.ok = hit_found_reg || free_found_reg;
                end
                sih_pkg::CMD_UNREGISTER:
                begin
                    rsp_next.ok = hit_found_reg;
                end
                sih_pkg::CMD_DISPATCH:
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_next.ok            = 1'b1;
                        rsp_next.entry_present = 1'b1;
                        rsp_next.slot_index    = sih_pkg::SLOT_IDX_W'(pend_slot_reg);
                        rsp_next.found_handler = pend_hnd_reg;
                        rsp_next.found_context = pend_ctx_reg;
                    end
                    else
                    begin
                        rsp_next.ok = line_ok_reg;
                    end
                end
                default:
                begin
                    rsp_next.ok            = line_ok_reg;
                    rsp_next.handler_count = count_reg;
                end
            endcase
        end
        else
        begin
            rsp_next.ok            = 1'b1;
            rsp_next.entry_present = 1'b1;
            rsp_next.slot_index    = sih_pkg::SLOT_IDX_W'(pend_slot_reg);
            rsp_next.found_handler = pend_hnd_reg;
            rsp_next.found_context = pend_ctx_reg;
        end
    end

    always_comb
    begin
        if (emit_step || cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (response_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            slot_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.clear_step)
            begin
                clear_addr_reg <= AW'(clear_addr_reg + AW'(1));
            end
            if (cmd.load_item)
            begin
                pend_valid_reg <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                slot_reg       <= '0;
                count_reg      <= '0;
            end
            else if (cmd.scan_step)
            begin
                if (!last_slot)
                begin
                    slot_reg <= SW'(slot_reg + SW'(1));
                end
                if ((is_register || is_unregister) && hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (is_register && !occupied && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (is_count && occupied)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (is_dispatch && occupied)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cmd_reg     <= request.command;
            hnd_reg     <= request.handler_tag;
            ctx_reg     <= request.context_tag;
            line_ok_reg <= line_ok_req;
            base_reg    <= base_req;
        end
        if (cmd.scan_step && is_register && !occupied && !free_found_reg)
        begin
            vacant_slot_reg <= slot_reg;
        end
        if (cmd.scan_step && is_dispatch && occupied)
        begin
            pend_slot_reg <= slot_reg;
            pend_hnd_reg  <= entry_hnd;
            pend_ctx_reg  <= entry_ctx;
        end
        if (emit_step || cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign response       = rsp_reg;
    assign response_valid = rsp_valid_reg;

endmodule

// ===== hdl/shared_irq_handler_table.sv =====
// Shared interrupt handler table: per-line slots of handler and context tags.
//
// The request channel (request_valid, request_ready, request) carries one
// command: register, unregister, dispatch or count for one interrupt line.
// The response channel (response_valid, response_ready, response) returns
// one transfer per command, except dispatch, which returns one transfer per
// occupied slot in slot order (or a single empty one); the last transfer of
// each command has last set.
// The tags sit in one RAM of LINE_COUNT * SLOTS_PER_LINE words. A command
// scans its line one slot per cycle, except while a dispatch scan waits on
// a stalled receiver; a rejected command skips the scan, and one that stops
// at a matching slot ends it early. The next command is accepted only after
// the finish state that follows the scan, where the final response is registered.
// After reset a clearing pass writes every RAM word to zero, during which
// request_ready stays low.
// The response is held in an output register; when the receiver stalls, a
// dispatch scan waits on the slot it has reached and the final response
// waits, so nothing is lost or repeated.
// Depends on sih_pkg, sih_ctrl, sih_datapath and sih_ram.
module shared_irq_handler_table #(
    parameter int LINE_COUNT = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_ready,
    input  sih_pkg::request_t  request,
    output logic               response_valid,
    input  logic               response_ready,
    output sih_pkg::response_t response
);

    sih_pkg::ctrl_cmd_t  cmd;
    sih_pkg::dp_status_t status;

    sih_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .status        (status),
        .cmd           (cmd)
    );

    sih_datapath #(
        .LINE_COUNT (LINE_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (request),
        .response       (response),
        .response_valid (response_valid),
        .response_ready (response_ready),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
